[hdl/aalu_pkg.sv]
// Shared types and constants of the accumulator ALU.
`default_nettype none

package aalu_pkg;

    // Operation codes.
    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_OR  = 3'd1;
    localparam logic [2:0] OP_XOR = 3'd2;
    localparam logic [2:0] OP_CMP = 3'd3;
    localparam logic [2:0] OP_DAA = 3'd4;
    localparam logic [2:0] OP_RLC = 3'd5;
    localparam logic [2:0] OP_RRC = 3'd6;
    localparam logic [2:0] OP_CPL = 3'd7;

    // Bit positions in the flag byte.
    localparam int unsigned FB_S  = 7;
    localparam int unsigned FB_Z  = 6;
    localparam int unsigned FB_Y  = 5;
    localparam int unsigned FB_H  = 4;
    localparam int unsigned FB_X  = 3;
    localparam int unsigned FB_PV = 2;
    localparam int unsigned FB_N  = 1;
    localparam int unsigned FB_C  = 0;

    // Decimal adjust corrections in the 10-bit intermediate.
    localparam logic [9:0] DAA_LO   = 10'h006;
    localparam logic [9:0] DAA_HI   = 10'h060;
    localparam logic [3:0] BCD_MAX  = 4'd9;
    localparam logic [7:0] BCD_BYTE = 8'h99;

    // One request as it enters the pipeline.
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] acc_in;
        logic [7:0] operand;
        logic [7:0] flags_in;
    } t_req;

    // First stage: results and the raw flag sources.
    typedef struct packed {
        logic       valid;
        logic [2:0] opcode;
        logic [7:0] acc;      // new accumulator
        logic [7:0] eval;     // byte that S, Z and parity are taken from
        logic [7:0] flags;    // incoming flag byte
        logic       carry;    // borrow, decimal carry or bit rotated out
        logic       half;     // compare half borrow
        logic       ovf;      // compare signed overflow
    } t_s1;

    // Second stage: the finished result.
    typedef struct packed {
        logic       valid;
        logic [7:0] acc;
        logic [7:0] flags;
    } t_s2;

endpackage

`default_nettype wire

[hdl/aalu_if.sv]
// Valid/ready channels for ALU requests and results.
`default_nettype none

interface aalu_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic [7:0] flags_in;

    modport source (output valid, output opcode, output acc_in, output operand,
                    output flags_in, input ready);
    modport sink   (input valid, input opcode, input acc_in, input operand,
                    input flags_in, output ready);
endinterface

interface aalu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] acc_out;
    logic [7:0] flags_out;

    modport source (output valid, output acc_out, output flags_out, input ready);
    modport sink   (input valid, input acc_out, input flags_out, output ready);
endinterface

`default_nettype wire

[hdl/aalu_exec.sv]
// First pipeline stage: computes the accumulator result and raw flag sources.
`default_nettype none

module aalu_exec (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire aalu_pkg::t_req i_req,
    output aalu_pkg::t_s1      o_s1
);

    aalu_pkg::t_s1 r_s1;
    aalu_pkg::t_s1 n_s1;

    logic [8:0] w_diff;
    logic [9:0] w_add;
    logic [9:0] w_sub1;
    logic [9:0] w_sub2;
    logic [9:0] w_daa;
    logic       w_h;
    logic       w_c;
    logic       w_n;

    assign w_h = i_req.flags_in[aalu_pkg::FB_H];
    assign w_c = i_req.flags_in[aalu_pkg::FB_C];
    assign w_n = i_req.flags_in[aalu_pkg::FB_N];

    // Compare difference with the borrow in bit 8.
    assign w_diff = {1'b0, i_req.acc_in} - {1'b0, i_req.operand};

    // Decimal adjust after an addition.
    always_comb begin
        w_add = {2'b00, i_req.acc_in};
        if (w_h || (i_req.acc_in[3:0] > aalu_pkg::BCD_MAX)) begin
            w_add = w_add + aalu_pkg::DAA_LO;
        end
        if (w_c || (i_req.acc_in > aalu_pkg::BCD_BYTE)) begin
            w_add = w_add + aalu_pkg::DAA_HI;
        end
    end

    // Decimal adjust after a subtraction; wraps within ten bits.
    always_comb begin
        w_sub1 = {2'b00, i_req.acc_in};
        if (w_h) begin
            w_sub1 = w_sub1 - aalu_pkg::DAA_LO;
            if (!w_c) begin
                w_sub1 = {2'b00, w_sub1[7:0]};
            end
        end
        w_sub2 = w_c ? (w_sub1 - aalu_pkg::DAA_HI) : w_sub1;
    end

    assign w_daa = w_n ? w_sub2 : w_add;

    // Result selection per operation.
    always_comb begin
        n_s1.valid  = i_valid;
        n_s1.opcode = i_req.opcode;
        n_s1.flags  = i_req.flags_in;
        n_s1.half   = i_req.acc_in[3:0] < i_req.operand[3:0];
        n_s1.ovf    = (i_req.acc_in[7] ^ i_req.operand[7]) &
                      (i_req.acc_in[7] ^ w_diff[7]);
        case (i_req.opcode)
            aalu_pkg::OP_AND: begin
                n_s1.acc   = i_req.acc_in & i_req.operand;
                n_s1.carry = 1'b0;
            end
            aalu_pkg::OP_OR: begin
                n_s1.acc   = i_req.acc_in | i_req.operand;
                n_s1.carry = 1'b0;
            end
            aalu_pkg::OP_XOR: begin
                n_s1.acc   = i_req.acc_in ^ i_req.operand;
                n_s1.carry = 1'b0;
            end
            aalu_pkg::OP_CMP: begin
                n_s1.acc   = i_req.acc_in;
                n_s1.carry = w_diff[8];
            end
            aalu_pkg::OP_DAA: begin
                n_s1.acc   = w_daa[7:0];
                n_s1.carry = w_daa[8];
            end
            aalu_pkg::OP_RLC: begin
                n_s1.acc   = {i_req.acc_in[6:0], i_req.acc_in[7]};
                n_s1.carry = i_req.acc_in[7];
            end
            aalu_pkg::OP_RRC: begin
                n_s1.acc   = {i_req.acc_in[0], i_req.acc_in[7:1]};
                n_s1.carry = i_req.acc_in[0];
            end
            default: begin
                n_s1.acc   = ~i_req.acc_in;
                n_s1.carry = 1'b0;
            end
        endcase
        n_s1.eval = (i_req.opcode == aalu_pkg::OP_CMP) ? w_diff[7:0] : n_s1.acc;
    end

    // Stage register: valid is reset, payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

[hdl/aalu_flags.sv]
// Second pipeline stage: assembles the new flag byte.
`default_nettype none

module aalu_flags (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire aalu_pkg::t_s1 i_s1,
    output aalu_pkg::t_s2     o_s2
);

    aalu_pkg::t_s2 r_s2;
    aalu_pkg::t_s2 n_s2;

    logic w_sign;
    logic w_zero;
    logic w_par;

    assign w_sign = i_s1.eval[7];
    assign w_zero = (i_s1.eval == 8'h00);
    assign w_par  = ~^i_s1.eval;

    // Flag byte per operation; bits 3 and 5 always pass through.
    always_comb begin
        n_s2.valid = i_s1.valid;
        n_s2.acc   = i_s1.acc;
        n_s2.flags = i_s1.flags;
        case (i_s1.opcode)
            aalu_pkg::OP_AND, aalu_pkg::OP_OR, aalu_pkg::OP_XOR: begin
                n_s2.flags[aalu_pkg::FB_S]  = w_sign;
                n_s2.flags[aalu_pkg::FB_Z]  = w_zero;
                n_s2.flags[aalu_pkg::FB_H]  = (i_s1.opcode == aalu_pkg::OP_AND);
                n_s2.flags[aalu_pkg::FB_PV] = w_par;
                n_s2.flags[aalu_pkg::FB_N]  = 1'b0;
                n_s2.flags[aalu_pkg::FB_C]  = 1'b0;
            end
            aalu_pkg::OP_CMP: begin
                n_s2.flags[aalu_pkg::FB_S]  = w_sign;
                n_s2.flags[aalu_pkg::FB_Z]  = w_zero;
                n_s2.flags[aalu_pkg::FB_H]  = i_s1.half;
                n_s2.flags[aalu_pkg::FB_PV] = i_s1.ovf;
                n_s2.flags[aalu_pkg::FB_N]  = 1'b1;
                n_s2.flags[aalu_pkg::FB_C]  = i_s1.carry;
            end
            aalu_pkg::OP_DAA: begin
                // Sign and N stay; carry can only be set here.
                n_s2.flags[aalu_pkg::FB_Z]  = w_zero;
                n_s2.flags[aalu_pkg::FB_H]  = 1'b0;
                n_s2.flags[aalu_pkg::FB_PV] = w_par;
                n_s2.flags[aalu_pkg::FB_C]  = i_s1.flags[aalu_pkg::FB_C] | i_s1.carry;
            end
            aalu_pkg::OP_RLC, aalu_pkg::OP_RRC: begin
                n_s2.flags[aalu_pkg::FB_H]  = 1'b0;
                n_s2.flags[aalu_pkg::FB_N]  = 1'b0;
                n_s2.flags[aalu_pkg::FB_C]  = i_s1.carry;
            end
            default: begin
                n_s2.flags[aalu_pkg::FB_H]  = 1'b1;
                n_s2.flags[aalu_pkg::FB_N]  = 1'b1;
            end
        endcase
    end

    // Stage register: valid is reset, payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

[hdl/accumulator_alu_with_flags.sv]
// Top level of the pipelined accumulator ALU.
// Eight-bit accumulator ALU with a Z80-style flag byte, three register stages.
// Requests arrive on i_req (opcode, acc_in, operand, flags_in) and results
// leave on o_rsp (acc_out, flags_out); both use valid/ready and move one
// request at each edge where valid and ready are high.
// A request passes through three register stages on its way to o_rsp and
// the pipeline takes one request per cycle while o_rsp is not stalled. Stage
// one forms the result byte and the raw carry, stage two builds the flag
// byte and stage three is the output register.
// The stages advance together whenever the output register is empty or
// its result is taken in the same cycle. When the receiver holds o_rsp.ready
// low with a result waiting, the pipeline freezes, i_req.ready drops and no
// request is lost or repeated; up to three requests are held in flight.
// Synchronous active-low reset clears all stage valid bits, so the block
// comes out of reset empty and ready.
`default_nettype none

module accumulator_alu_with_flags (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    aalu_req_if.sink  i_req,
    aalu_rsp_if.source o_rsp
);

    aalu_pkg::t_req w_req;
    aalu_pkg::t_s1  w_s1;
    aalu_pkg::t_s2  w_s2;
    aalu_pkg::t_s2  r_out;
    logic           w_adv;

    // The whole pipeline moves when the output register can take a result.
    assign w_adv       = !r_out.valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    assign w_req = '{opcode:   i_req.opcode,
                     acc_in:   i_req.acc_in,
                     operand:  i_req.operand,
                     flags_in: i_req.flags_in};

    // Stage one: result byte and raw flag sources.
    aalu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_req.valid),
        .i_req   (w_req),
        .o_s1    (w_s1)
    );

    // Stage two: flag byte.
    aalu_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_s1    (w_s1),
        .o_s2    (w_s2)
    );

    // Stage three: output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_adv) begin
            r_out <= w_s2;
        end
    end

    assign o_rsp.valid     = r_out.valid;
    assign o_rsp.acc_out   = r_out.acc;
    assign o_rsp.flags_out = r_out.flags;

`ifndef SYNTHESIS
    // A result in stage two reaches the output when the pipeline moves.
    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2.valid && w_adv) |=> o_rsp.valid)
        else $error("stage two result did not reach the output");

    // Flag bits 3 and 5 are carried unchanged through the flag stage.
    a_keep_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1.valid && w_adv) |=>
            (w_s2.flags[aalu_pkg::FB_Y] == $past(w_s1.flags[aalu_pkg::FB_Y])) &&
            (w_s2.flags[aalu_pkg::FB_X] == $past(w_s1.flags[aalu_pkg::FB_X])))
        else $error("flag bits 3 or 5 altered");

    // An empty output register never blocks new requests.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("request blocked while output is empty");

    // A frozen pipeline keeps its stage valid bits.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_s1.valid) && $stable(w_s2.valid))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

[dv/accumulator_alu_with_flags_test.sv]
// Self-checking testbench for the accumulator ALU with random flow control on both channels.
`timescale 1ns / 100ps

module accumulator_alu_with_flags_test;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned MAX_REPORTS  = 10;

    // One expected result together with the request that caused it.
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] acc_in;
        logic [7:0] operand;
        logic [7:0] flags_in;
        logic [7:0] acc;
        logic [7:0] flags;
    } t_alu_result;

    logic i_clk;
    logic i_rst_n;

    aalu_req_if req_if ();
    aalu_rsp_if rsp_if ();

    accumulator_alu_with_flags dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_alu_result pending_alu_results[$];
    t_alu_result arrived_result;
    int unsigned mismatch_count;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned op_count[8];
    int unsigned cycle_count;
    int unsigned hold_requests;
    bit          req_idle_on;
    bit          rsp_idle_on;

    // Free-running clock, 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Cycle counter for the timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Expected accumulator and flag byte for one request.
    function automatic void compute_alu_result(input logic [2:0] op, input logic [7:0] a,
                                               input logic [7:0] b, input logic [7:0] f,
                                               output logic [7:0] r, output logic [7:0] nf);
        logic [7:0] diff;
        logic [9:0] adj;
        r  = a;
        nf = f;
        case (op)
            aalu_pkg::OP_AND, aalu_pkg::OP_OR, aalu_pkg::OP_XOR: begin
                if (op == aalu_pkg::OP_AND) begin
                    r = a & b;
                end else if (op == aalu_pkg::OP_OR) begin
                    r = a | b;
                end else begin
                    r = a ^ b;
                end
                nf[aalu_pkg::FB_S]  = r[7];
                nf[aalu_pkg::FB_Z]  = (r == 8'h00);
                nf[aalu_pkg::FB_PV] = ~^r;
                nf[aalu_pkg::FB_H]  = (op == aalu_pkg::OP_AND);
                nf[aalu_pkg::FB_N]  = 1'b0;
                nf[aalu_pkg::FB_C]  = 1'b0;
            end
            aalu_pkg::OP_CMP: begin
                diff                = a - b;
                nf[aalu_pkg::FB_S]  = diff[7];
                nf[aalu_pkg::FB_Z]  = (diff == 8'h00);
                nf[aalu_pkg::FB_PV] = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
                nf[aalu_pkg::FB_H]  = (a[3:0] < b[3:0]);
                nf[aalu_pkg::FB_N]  = 1'b1;
                nf[aalu_pkg::FB_C]  = (a < b);
            end
            aalu_pkg::OP_DAA: begin
                // The correction is formed in ten bits; carry is the incoming carry or bit 8.
                adj = {2'b00, a};
                if (!f[aalu_pkg::FB_N]) begin
                    if (f[aalu_pkg::FB_H] || a[3:0] > aalu_pkg::BCD_MAX) begin
                        adj = adj + aalu_pkg::DAA_LO;
                    end
                    if (f[aalu_pkg::FB_C] || a > aalu_pkg::BCD_BYTE) begin
                        adj = adj + aalu_pkg::DAA_HI;
                    end
                end else begin
                    if (f[aalu_pkg::FB_H]) begin
                        adj = adj - aalu_pkg::DAA_LO;
                        if (!f[aalu_pkg::FB_C]) adj[9:8] = 2'b00;
                    end
                    if (f[aalu_pkg::FB_C]) adj = adj - aalu_pkg::DAA_HI;
                end
                r                   = adj[7:0];
                nf[aalu_pkg::FB_Z]  = (r == 8'h00);
                nf[aalu_pkg::FB_PV] = ~^r;
                nf[aalu_pkg::FB_H]  = 1'b0;
                nf[aalu_pkg::FB_C]  = f[aalu_pkg::FB_C] | adj[8];
            end
            aalu_pkg::OP_RLC: begin
                r                  = {a[6:0], a[7]};
                nf[aalu_pkg::FB_H] = 1'b0;
                nf[aalu_pkg::FB_N] = 1'b0;
                nf[aalu_pkg::FB_C] = a[7];
            end
            aalu_pkg::OP_RRC: begin
                r                  = {a[0], a[7:1]};
                nf[aalu_pkg::FB_H] = 1'b0;
                nf[aalu_pkg::FB_N] = 1'b0;
                nf[aalu_pkg::FB_C] = a[0];
            end
            default: begin
                r                  = ~a;
                nf[aalu_pkg::FB_H] = 1'b1;
                nf[aalu_pkg::FB_N] = 1'b1;
            end
        endcase
    endfunction

    // Counts a failure and prints the first few.
    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // Byte with extra weight on the two extremes.
    function automatic logic [7:0] pick_byte();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Offers one request after a random gap and records its expected result once taken.
    task automatic send_request(input logic [2:0] op, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] f);
        int unsigned gap;
        t_alu_result exp_res;
        gap = req_idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.acc_in   <= a;
        req_if.operand  <= b;
        req_if.flags_in <= f;
        do @(posedge i_clk); while (!req_if.ready);
        exp_res.opcode   = op;
        exp_res.acc_in   = a;
        exp_res.operand  = b;
        exp_res.flags_in = f;
        compute_alu_result(op, a, b, f, exp_res.acc, exp_res.flags);
        pending_alu_results.push_back(exp_res);
        sent_count++;
        op_count[op]++;
    endtask

    // Receiver: random stalls per result, plus long holds on request.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned holds_seen;
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        hold_left    = 0;
        holds_seen   = 0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (rsp_if.valid && rsp_if.ready) begin
                    stall_left = rsp_idle_on ? $urandom_range(0, 8) : 0;
                end else if (stall_left != 0) begin
                    stall_left--;
                end
                rsp_if.ready <= (stall_left == 0);
            end
        end
    end

    // Result checker: each taken result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_alu_results.size() == 0) begin
                report_failure($sformatf("result acc=%02h flags=%02h with none expected",
                                         rsp_if.acc_out, rsp_if.flags_out));
            end else begin
                arrived_result = pending_alu_results.pop_front();
                checked_count++;
                if (rsp_if.acc_out !== arrived_result.acc) begin
                    report_failure($sformatf(
                        "op %0d a=%02h b=%02h f=%02h: acc expected %02h, got %02h",
                        arrived_result.opcode, arrived_result.acc_in, arrived_result.operand,
                        arrived_result.flags_in, arrived_result.acc, rsp_if.acc_out));
                end
                if (rsp_if.flags_out !== arrived_result.flags) begin
                    report_failure($sformatf(
                        "op %0d a=%02h b=%02h f=%02h: flags expected %02h, got %02h",
                        arrived_result.opcode, arrived_result.acc_in, arrived_result.operand,
                        arrived_result.flags_in, arrived_result.flags, rsp_if.flags_out));
                end
            end
        end
    end

    // Timeout.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_alu_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Logic operations at the extremes, with the operand used.
    task automatic test_logic_ops();
        send_request(aalu_pkg::OP_AND, 8'hFF, 8'hFF, 8'h00);
        send_request(aalu_pkg::OP_AND, 8'h00, 8'hFF, 8'hFF);
        send_request(aalu_pkg::OP_OR,  8'h00, 8'h00, 8'hFF);
        send_request(aalu_pkg::OP_OR,  8'h80, 8'h01, 8'h00);
        send_request(aalu_pkg::OP_XOR, 8'hFF, 8'hFF, 8'h28);
        send_request(aalu_pkg::OP_XOR, 8'h55, 8'hAA, 8'hD7);
    endtask

    // Compare: equal, borrow, half borrow and signed overflow both ways.
    task automatic test_compare();
        send_request(aalu_pkg::OP_CMP, 8'h42, 8'h42, 8'h00);
        send_request(aalu_pkg::OP_CMP, 8'h00, 8'h01, 8'hFF);
        send_request(aalu_pkg::OP_CMP, 8'h80, 8'h01, 8'h00);
        send_request(aalu_pkg::OP_CMP, 8'h7F, 8'hFF, 8'h00);
        send_request(aalu_pkg::OP_CMP, 8'hFF, 8'h00, 8'h28);
    endtask

    // Decimal adjust after addition and after subtraction, with carry and half carry.
    task automatic test_decimal_adjust();
        send_request(aalu_pkg::OP_DAA, 8'h9A, 8'($urandom), 8'h00);
        send_request(aalu_pkg::OP_DAA, 8'h00, 8'($urandom), 8'h11);
        send_request(aalu_pkg::OP_DAA, 8'h99, 8'($urandom), 8'h80);
        send_request(aalu_pkg::OP_DAA, 8'hFF, 8'($urandom), 8'h01);
        send_request(aalu_pkg::OP_DAA, 8'h05, 8'($urandom), 8'h12);
        send_request(aalu_pkg::OP_DAA, 8'h00, 8'($urandom), 8'h13);
        send_request(aalu_pkg::OP_DAA, 8'h66, 8'($urandom), 8'h03);
        send_request(aalu_pkg::OP_DAA, 8'h12, 8'($urandom), 8'hAA);
    endtask

    // Rotates and complement; the operand is random and must be ignored.
    task automatic test_rotate_complement();
        send_request(aalu_pkg::OP_RLC, 8'h80, 8'($urandom), 8'hC4);
        send_request(aalu_pkg::OP_RLC, 8'h01, 8'($urandom), 8'h13);
        send_request(aalu_pkg::OP_RRC, 8'h01, 8'($urandom), 8'h00);
        send_request(aalu_pkg::OP_RRC, 8'h80, 8'($urandom), 8'hFF);
        send_request(aalu_pkg::OP_CPL, 8'h00, 8'($urandom), 8'h00);
        send_request(aalu_pkg::OP_CPL, 8'hFF, 8'($urandom), 8'hFF);
    endtask

    // Random requests in blocks, each block with its own mix of idling.
    task automatic test_random_mix();
        int unsigned mode;
        for (int blk = 0; blk < 12; blk++) begin
            mode        = $urandom_range(0, 3);
            req_idle_on = mode[0];
            rsp_idle_on = mode[1];
            for (int n = 0; n < 85; n++) begin
                send_request(3'($urandom_range(0, 7)), pick_byte(), pick_byte(), pick_byte());
            end
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_back_pressure();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        hold_requests++;
        for (int n = 0; n < 60; n++) begin
            send_request(3'($urandom_range(0, 7)), pick_byte(), pick_byte(), pick_byte());
        end
        rsp_idle_on = 1'b1;
        hold_requests++;
        for (int n = 0; n < 40; n++) begin
            send_request(3'($urandom_range(0, 7)), pick_byte(), pick_byte(), pick_byte());
        end
    endtask

    // Reset, the tests in turn, drain and verdict.
    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = aalu_pkg::OP_AND;
        req_if.acc_in    = 8'h00;
        req_if.operand   = 8'h00;
        req_if.flags_in  = 8'h00;
        mismatch_count   = 0;
        sent_count       = 0;
        checked_count    = 0;
        cycle_count      = 0;
        hold_requests    = 0;
        req_idle_on      = 1'b1;
        rsp_idle_on      = 1'b1;
        foreach (op_count[i]) op_count[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_logic_ops();
        test_compare();
        test_decimal_adjust();
        test_rotate_complement();
        test_random_mix();
        test_back_pressure();

        req_if.valid <= 1'b0;
        while (pending_alu_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results in %0d cycles",
                 sent_count, checked_count, cycle_count);
        $display("Per operation: and %0d or %0d xor %0d cmp %0d daa %0d rlc %0d rrc %0d cpl %0d",
                 op_count[aalu_pkg::OP_AND], op_count[aalu_pkg::OP_OR],
                 op_count[aalu_pkg::OP_XOR], op_count[aalu_pkg::OP_CMP],
                 op_count[aalu_pkg::OP_DAA], op_count[aalu_pkg::OP_RLC],
                 op_count[aalu_pkg::OP_RRC], op_count[aalu_pkg::OP_CPL]);
        if (mismatch_count == 0 && pending_alu_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
